// ===== rtl/core/rbs_pkg.sv =====
`timescale 1ns / 1ps

package rbs_pkg;

  localparam int DEPTH      = 16;
  localparam int SLOT_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int TAG_W      = 16;
  localparam int SIZE_W     = 31;
  localparam int BATCH_W    = 32;
  localparam int BSIZE_W    = 16;
  localparam int POLICY_W   = 2;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 4;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH  = 1'd1;

  localparam logic [POLICY_W-1:0] POL_FIFO = 2'd0;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_TAKE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED   = 3'd0,
    ST_DROPPED = 3'd1,
    ST_FULL    = 3'd2,
    ST_TAKEN   = 3'd3,
    ST_NONE    = 3'd4
  } status_t;

  typedef struct packed {
    logic [BATCH_W-1:0] batch;
    logic [TAG_W-1:0]   tag;
    logic [SIZE_W-1:0]  size;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic scan_start;
    logic scan_run;
    logic commit;
  } rbs_cmd_t;

  typedef struct packed {
    logic scan_done;
  } rbs_sts_t;

endpackage

// ===== rtl/core/request_buffer_scheduler_core.sv =====
`timescale 1ns / 1ps
// Add request: after acceptance the controller enters its done state and registers the result on commit.
// Take request: the result follows a one-slot-per-cycle scan of the slot memory through
// its single registered read port, then is registered on commit in the done state.
// One request in flight; the next is accepted while a result waits on out_tready.
// Synchronous active-low reset clears valid bits, pointers and counters and resets config and scan control;
// slot contents and the request and result registers stay undefined until written.
module request_buffer_scheduler_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rbs_pkg::IN_DATA_W-1:0]   in_tdata,   // tag, size, parse_ok
  input  logic                            in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rbs_pkg::OUT_DATA_W-1:0]  out_tdata,  // out_tag, out_size, slot, zero pad
  output logic [rbs_pkg::STATUS_W-1:0]    out_tuser   // status
);
  import rbs_pkg::*;

  rbs_cmd_t cmd;
  rbs_sts_t sts;

  rbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rbs_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_action  (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_tuser),
    .out_data   (out_tdata)
  );

endmodule

// ===== rtl/core/rbs_ctrl.sv =====
`timescale 1ns / 1ps

module rbs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_action,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  rbs_pkg::rbs_sts_t sts,
  output rbs_pkg::rbs_cmd_t cmd
);
  import rbs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   accept;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.capture    = accept;
    cmd.scan_start = accept && (in_action == ACT_TAKE);
    cmd.scan_run   = (state_r == S_SCAN);
    cmd.commit     = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (in_action == ACT_TAKE) ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (sts.scan_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (cmd.commit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/rbs_datapath.sv =====
`timescale 1ns / 1ps

module rbs_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_action,
  input  logic [rbs_pkg::IN_DATA_W-1:0]     in_tdata,
  input  rbs_pkg::rbs_cmd_t                 cmd,
  output rbs_pkg::rbs_sts_t                 sts,
  output logic [rbs_pkg::STATUS_W-1:0]      out_status,
  output logic [rbs_pkg::OUT_DATA_W-1:0]    out_data
);
  import rbs_pkg::*;

  logic [POLICY_W-1:0] policy_r;
  logic [BSIZE_W-1:0]  batch_size_r;

  logic [DEPTH-1:0]    valid_r;
  logic [SLOT_W-1:0]   fill_ptr_r;
  logic [SLOT_W-1:0]   take_ptr_r;
  logic [CNT_W-1:0]    occ_r;
  logic [BATCH_W-1:0]  arr_batch_r;
  logic [BSIZE_W-1:0]  arr_in_r;
  logic [BATCH_W-1:0]  epoch_r;
  logic [BSIZE_W-1:0]  taken_r;

  logic                req_action_r;
  logic [TAG_W-1:0]    req_tag_r;
  logic [SIZE_W-1:0]   req_size_r;
  logic                req_ok_r;

  entry_t              mem [DEPTH];
  entry_t              rd_data_r;

  logic [CNT_W-1:0]    rd_idx_r;
  logic                pend_r;
  logic [SLOT_W-1:0]   pend_idx_r;
  logic                found_r;
  logic [SLOT_W-1:0]   best_idx_r;
  logic [SIZE_W-1:0]   best_size_r;
  logic [TAG_W-1:0]    best_tag_r;

  status_t             out_status_r;
  logic [TAG_W-1:0]    out_tag_r;
  logic [SIZE_W-1:0]   out_size_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;

  logic                is_fifo;
  logic                batched;
  logic [BSIZE_W-1:0]  eff_batch;
  logic                arr_wrap;
  logic                taken_wrap;
  logic                free_any;
  logic [SLOT_W-1:0]   free_idx;
  logic                add_found;
  logic [SLOT_W-1:0]   add_target;
  status_t             add_status;
  logic                elig;
  logic                do_add;
  logic                do_take;

  assign is_fifo   = (policy_r == POL_FIFO);
  assign batched   = policy_r[1];
  assign eff_batch = (batch_size_r == '0) ? BSIZE_W'(1) : batch_size_r;
  assign arr_wrap  = ({1'b0, arr_in_r} + (BSIZE_W+1)'(1)) >= {1'b0, eff_batch};
  assign taken_wrap = ({1'b0, taken_r} + (BSIZE_W+1)'(1)) >= {1'b0, eff_batch};

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    add_found  = 1'b0;
    add_target = '0;
    if (occ_r < CNT_W'(DEPTH)) begin
      if (is_fifo) begin
        add_found  = !valid_r[fill_ptr_r];
        add_target = fill_ptr_r;
      end else begin
        add_found  = free_any;
        add_target = free_idx;
      end
    end
    if (!add_found) begin
      add_status = ST_FULL;
    end else if (!req_ok_r) begin
      add_status = ST_DROPPED;
    end else begin
      add_status = ST_ADDED;
    end
  end

  always_comb begin
    if (is_fifo) begin
      elig = valid_r[pend_idx_r] && (pend_idx_r == take_ptr_r);
    end else begin
      elig = valid_r[pend_idx_r] && (!batched || (rd_data_r.batch <= epoch_r));
    end
  end

  assign do_add  = cmd.commit && (req_action_r == ACT_ADD) && (add_status == ST_ADDED);
  assign do_take = cmd.commit && (req_action_r == ACT_TAKE) && found_r;

  assign sts.scan_done = (rd_idx_r == CNT_W'(DEPTH)) && !pend_r;

  assign out_status = out_status_r;
  assign out_data   = {5'd0, out_slot_r, out_size_r, out_tag_r};

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_idx_r[SLOT_W-1:0]];
    if (do_add) begin
      mem[add_target] <= '{batch: arr_batch_r, tag: req_tag_r, size: req_size_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_action_r <= in_action;
      req_tag_r    <= in_tdata[15:0];
      req_size_r   <= in_tdata[46:16];
      req_ok_r     <= in_tdata[47];
    end
    if (pend_r && elig && (!found_r || (rd_data_r.size < best_size_r))) begin
      best_idx_r  <= pend_idx_r;
      best_size_r <= rd_data_r.size;
      best_tag_r  <= rd_data_r.tag;
    end
    pend_idx_r <= rd_idx_r[SLOT_W-1:0];
    if (cmd.commit) begin
      if (req_action_r == ACT_ADD) begin
        out_status_r <= add_status;
        out_tag_r    <= '0;
        out_size_r   <= '0;
        out_slot_r   <= (add_status == ST_ADDED) ? OUT_SLOT_W'(add_target) : '0;
      end else if (found_r) begin
        out_status_r <= ST_TAKEN;
        out_tag_r    <= best_tag_r;
        out_size_r   <= best_size_r;
        out_slot_r   <= OUT_SLOT_W'(best_idx_r);
      end else begin
        out_status_r <= ST_NONE;
        out_tag_r    <= '0;
        out_size_r   <= '0;
        out_slot_r   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POL_FIFO;
      batch_size_r <= BSIZE_W'(1);
      valid_r      <= '0;
      fill_ptr_r   <= '0;
      take_ptr_r   <= '0;
      occ_r        <= '0;
      arr_batch_r  <= '0;
      arr_in_r     <= '0;
      epoch_r      <= '0;
      taken_r      <= '0;
      rd_idx_r     <= CNT_W'(DEPTH);
      pend_r       <= 1'b0;
      found_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_POLICY: policy_r     <= cfg_wdata[POLICY_W-1:0];
          CFG_BATCH:  batch_size_r <= cfg_wdata[BSIZE_W-1:0];
          default: begin
          end
        endcase
      end

      if (cmd.scan_start) begin
        rd_idx_r <= '0;
        pend_r   <= 1'b0;
        found_r  <= 1'b0;
      end else if (cmd.scan_run) begin
        if (rd_idx_r != CNT_W'(DEPTH)) begin
          rd_idx_r <= rd_idx_r + CNT_W'(1);
          pend_r   <= 1'b1;
        end else begin
          pend_r   <= 1'b0;
        end
        if (pend_r && elig) begin
          found_r <= 1'b1;
        end
      end

      if (cmd.commit && (req_action_r == ACT_ADD)) begin
        if (arr_wrap) begin
          arr_in_r    <= '0;
          arr_batch_r <= arr_batch_r + BATCH_W'(1);
        end else begin
          arr_in_r    <= arr_in_r + BSIZE_W'(1);
        end
      end

      if (do_add) begin
        valid_r[add_target] <= 1'b1;
        occ_r               <= occ_r + CNT_W'(1);
        if (is_fifo) begin
          fill_ptr_r <= (fill_ptr_r == SLOT_W'(DEPTH - 1)) ? '0 : fill_ptr_r + SLOT_W'(1);
        end
      end

      if (do_take) begin
        valid_r[best_idx_r] <= 1'b0;
        if (occ_r != '0) begin
          occ_r <= occ_r - CNT_W'(1);
        end
        if (is_fifo) begin
          take_ptr_r <= (take_ptr_r == SLOT_W'(DEPTH - 1)) ? '0 : take_ptr_r + SLOT_W'(1);
        end
        if (taken_wrap) begin
          taken_r <= '0;
          if (batched) begin
            epoch_r <= epoch_r + BATCH_W'(1);
          end
        end else begin
          taken_r <= taken_r + BSIZE_W'(1);
        end
      end
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rbs_pkg::*;

  localparam logic [POLICY_W-1:0] POL_SJF       = 2'd1;
  localparam logic [POLICY_W-1:0] POL_BATCH     = 2'd2;
  localparam logic [POLICY_W-1:0] POL_BATCH_ALT = 2'd3;
  localparam int MAX_PRINTS = 100;

  typedef struct {
    logic              act;
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size;
    logic              ok;
  } req_item_t;

  typedef struct {
    status_t               status;
    logic [TAG_W-1:0]      tag;
    logic [SIZE_W-1:0]     size;
    logic [OUT_SLOT_W-1:0] slot;
  } outcome_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;

  req_item_t request_q[$];
  outcome_t  outcome_q[$];
  req_item_t presented;
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // scheduler state as the testbench sees it
  logic [POLICY_W-1:0] mode_reg  = POL_FIFO;
  int unsigned         batch_reg = 1;
  bit                  slot_used [DEPTH];
  logic [SIZE_W-1:0]   slot_key [DEPTH];
  logic [TAG_W-1:0]    slot_handle [DEPTH];
  int unsigned         slot_group [DEPTH];
  logic [SLOT_W-1:0]   ring_tail = '0;
  logic [SLOT_W-1:0]   ring_head = '0;
  int                  used_count = 0;
  int unsigned         arrival_group = 0;
  int unsigned         arrival_pos = 0;
  int unsigned         epoch = 0;
  int unsigned         served_pos = 0;

  logic [POLICY_W-1:0]   clean_pol [4] = '{POL_BATCH, POL_BATCH_ALT, POL_BATCH, POL_BATCH};
  logic [CFG_DATA_W-1:0] clean_bs [4]  = '{16'd1, 16'd3, 16'd0, 16'hFFFF};
  int                    clean_n [4]   = '{80, 80, 60, 80};
  logic [POLICY_W-1:0]   mixed_pol [6] =
    '{POL_FIFO, POL_SJF, POL_FIFO, POL_SJF, POL_BATCH_ALT, POL_FIFO};
  logic [CFG_DATA_W-1:0] mixed_bs [6]  = '{16'd5, 16'd1, 16'hFFFF, 16'd2, 16'd4, 16'd1};
  int                    mixed_n [6]   = '{100, 100, 80, 80, 60, 80};

  always #2 clk = ~clk;

  request_buffer_scheduler_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  function automatic outcome_t schedule_outcome(req_item_t r);
    outcome_t    res;
    int unsigned span;
    int unsigned my_group;
    int          pick;
    bit          found;
    res.status = ST_ADDED;
    res.tag    = '0;
    res.size   = '0;
    res.slot   = '0;
    span       = (batch_reg == 0) ? 1 : batch_reg;
    pick       = 0;
    found      = 1'b0;
    if (r.act == ACT_ADD) begin
      my_group = arrival_group;
      if (arrival_pos + 1 >= span) begin
        arrival_pos   = 0;
        arrival_group = arrival_group + 1;
      end else begin
        arrival_pos = arrival_pos + 1;
      end
      if (used_count < DEPTH) begin
        if (mode_reg == POL_FIFO) begin
          if (!slot_used[ring_tail]) begin
            pick  = ring_tail;
            found = 1'b1;
          end
        end else begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!found && !slot_used[i]) begin
              pick  = i;
              found = 1'b1;
            end
          end
        end
      end
      if (!found) begin
        res.status = ST_FULL;
      end else if (!r.ok) begin
        res.status = ST_DROPPED;
      end else begin
        slot_used[pick]   = 1'b1;
        slot_key[pick]    = r.size;
        slot_handle[pick] = r.tag;
        slot_group[pick]  = my_group;
        used_count++;
        if (mode_reg == POL_FIFO) ring_tail = ring_tail + SLOT_W'(1);
        res.slot = OUT_SLOT_W'(pick);
      end
    end else begin
      if (mode_reg == POL_FIFO) begin
        if (slot_used[ring_head]) begin
          pick  = ring_head;
          found = 1'b1;
        end
      end else begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && !(mode_reg >= POL_BATCH && slot_group[i] > epoch) &&
              (!found || slot_key[i] < slot_key[pick])) begin
            pick  = i;
            found = 1'b1;
          end
        end
      end
      if (!found) begin
        res.status = ST_NONE;
      end else begin
        slot_used[pick] = 1'b0;
        if (used_count > 0) used_count--;
        if (mode_reg == POL_FIFO) ring_head = ring_head + SLOT_W'(1);
        if (served_pos + 1 >= span) begin
          served_pos = 0;
          if (mode_reg >= POL_BATCH) epoch = epoch + 1;
        end else begin
          served_pos = served_pos + 1;
        end
        res.status = ST_TAKEN;
        res.tag    = slot_handle[pick];
        res.size   = slot_key[pick];
        res.slot   = OUT_SLOT_W'(pick);
      end
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTS)
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic check_result();
    outcome_t want;
    if (outcome_q.size() == 0) begin
      flag_mismatch("unexpected result, status", 0, out_tuser);
      return;
    end
    want = outcome_q.pop_front();
    if (out_tuser !== want.status) flag_mismatch("status", want.status, out_tuser);
    if (out_tdata[TAG_W-1:0] !== want.tag)
      flag_mismatch("out_tag", want.tag, out_tdata[TAG_W-1:0]);
    if (out_tdata[TAG_W+SIZE_W-1:TAG_W] !== want.size)
      flag_mismatch("out_size", want.size, out_tdata[TAG_W+SIZE_W-1:TAG_W]);
    if (out_tdata[TAG_W+SIZE_W+OUT_SLOT_W-1:TAG_W+SIZE_W] !== want.slot)
      flag_mismatch("slot", want.slot, out_tdata[TAG_W+SIZE_W+OUT_SLOT_W-1:TAG_W+SIZE_W]);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) outcome_q.push_back(schedule_outcome(presented));
      if (!in_tvalid || in_tready) begin
        if (request_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          presented = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {presented.ok, presented.size, presented.tag};
          in_tuser  <= presented.act;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom_range(15));
      default: return SIZE_W'($urandom);
    endcase
  endfunction

  task automatic push_req(input logic act, input logic [TAG_W-1:0] tag,
                          input logic [SIZE_W-1:0] size, input logic ok);
    req_item_t r;
    r.act  = act;
    r.tag  = tag;
    r.size = size;
    r.ok   = ok;
    request_q.push_back(r);
  endtask

  // clean: every add parses and never meets a full buffer; drain at the end
  task automatic queue_random(input int count, input bit clean);
    int   add_pct;
    int   occ_est;
    logic act;
    add_pct = 50;
    occ_est = used_count;
    for (int k = 0; k < count; k++) begin
      if (k % 16 == 0) add_pct = 25 * $urandom_range(1, 3);
      act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_TAKE;
      if (clean) begin
        if (occ_est == DEPTH) act = ACT_TAKE;
        else if (occ_est == 0 && $urandom_range(19) != 0) act = ACT_ADD;
      end
      push_req(act, TAG_W'($urandom), pick_size(),
               clean ? 1'b1 : ($urandom_range(9) != 0));
      if (act == ACT_ADD) occ_est++;
      else if (occ_est > 0) occ_est--;
    end
    if (clean) begin
      repeat (occ_est) push_req(ACT_TAKE, TAG_W'($urandom), pick_size(), 1'($urandom));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_POLICY) mode_reg = val[POLICY_W-1:0];
    else batch_reg = val;
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_tvalid || outcome_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
      default: begin send_idle_pct = 13; recv_stall_pct = 13; end
    endcase
  endtask

  initial begin
    int phase;
    phase = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // batched: the smaller late arrival waits for its epoch
    write_reg(CFG_POLICY, POL_BATCH);
    write_reg(CFG_BATCH, 16'd2);
    @(negedge clk);
    push_req(ACT_TAKE, '1, '1, 1'b1);
    push_req(ACT_ADD, '0, '1, 1'b1);
    push_req(ACT_ADD, '1, '0, 1'b1);
    push_req(ACT_ADD, 16'h1234, 31'd1, 1'b1);
    repeat (3) push_req(ACT_TAKE, '0, '0, 1'b0);
    wait_drained();

    // keep arrivals and epochs in step: no drops, no full buffer
    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_POLICY, clean_pol[p]);
      write_reg(CFG_BATCH, clean_bs[p]);
      @(negedge clk);
      set_idling(phase++);
      queue_random(clean_n[p], 1'b1);
      wait_drained();
    end

    // ring tail taken by a shortest-first entry, head invalid, drop, full ring
    write_reg(CFG_POLICY, POL_SJF);
    @(negedge clk);
    set_idling(0);
    push_req(ACT_ADD, '1, '1, 1'b1);
    push_req(ACT_ADD, '0, '0, 1'b1);
    wait_drained();
    write_reg(CFG_POLICY, POL_FIFO);
    @(negedge clk);
    push_req(ACT_ADD, 16'h00FF, 31'd9, 1'b1);
    repeat (3) push_req(ACT_TAKE, '0, '0, 1'b1);
    push_req(ACT_ADD, 16'hA5A5, 31'd3, 1'b0);
    repeat (DEPTH) push_req(ACT_ADD, TAG_W'($urandom), pick_size(), 1'b1);
    push_req(ACT_ADD, 16'h5A5A, '1, 1'b0);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      // drain before entering ring mode so the pointers cannot deadlock
      if (mixed_pol[p] == POL_FIFO && mode_reg != POL_FIFO && used_count > 0) begin
        write_reg(CFG_POLICY, POL_SJF);
        @(negedge clk);
        repeat (used_count) push_req(ACT_TAKE, TAG_W'($urandom), pick_size(), 1'($urandom));
        wait_drained();
      end
      write_reg(CFG_POLICY, mixed_pol[p]);
      write_reg(CFG_BATCH, mixed_bs[p]);
      @(negedge clk);
      set_idling(phase++);
      queue_random(mixed_n[p], 1'b0);
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rbs_pkg.sv
rtl/core/rbs_ctrl.sv
rtl/core/rbs_datapath.sv
rtl/core/request_buffer_scheduler_core.sv
tb/sv/tb.sv
